// ----- src/f32d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32d_pkg
// Shared types and constants of the single-precision divider.
// ----------------------------------------------------------------------------
package f32d_pkg;

	localparam int unsigned QuoBits = 25;
	localparam int unsigned SigW    = 24;
	localparam int unsigned RemW    = 25;
	localparam int unsigned ExpW    = 10;
	localparam logic signed [ExpW-1:0] ExpBias = 10'sd127;
	localparam logic signed [ExpW-1:0] ExpMax  = 10'sd254;
	localparam logic [31:0] InfWord = 32'h7F80_0000;
	localparam logic [23:0] HiddenBit = 24'h80_0000;

	// State handed from one cell of the division row to the next.
	typedef struct packed {
		logic                   vld;
		logic                   sign;
		logic signed [ExpW-1:0] expo;
		logic [RemW-1:0]        rem;
		logic [SigW-1:0]        dvs;
		logic [QuoBits-1:0]     quo;
	} f32d_cell_t;

endpackage

// ----- src/f32d_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32d_cell
// One restoring-division step: a trial subtract, one quotient bit, a shift.
// ----------------------------------------------------------------------------
module f32d_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  f32d_pkg::f32d_cell_t cell_in,
	output f32d_pkg::f32d_cell_t cell_out
);

	f32d_pkg::f32d_cell_t          cell_q;
	logic [f32d_pkg::RemW:0]       diff;
	logic                          take;
	logic [f32d_pkg::RemW-1:0]     rem_next;

	always_comb begin
		diff     = {1'b0, cell_in.rem} - {2'b00, cell_in.dvs};
		take     = ~diff[f32d_pkg::RemW];
		rem_next = take ? {diff[f32d_pkg::RemW-2:0], 1'b0}
		                : {cell_in.rem[f32d_pkg::RemW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (advance) begin
			cell_q.vld  <= cell_in.vld;
			cell_q.sign <= cell_in.sign;
			cell_q.expo <= cell_in.expo;
			cell_q.dvs  <= cell_in.dvs;
			cell_q.rem  <= rem_next;
			cell_q.quo  <= {cell_in.quo[f32d_pkg::QuoBits-2:0], take};
		end
	end

	assign cell_out = cell_q;

endmodule

// ----- src/f32d_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f32d_round
// Final stage: saturate overflow to infinity, else denormalize, round to nearest even and pack, with output register.
// ----------------------------------------------------------------------------
module f32d_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  f32d_pkg::f32d_cell_t cell_in,
	output logic                 out_vld,
	output logic [31:0]          out_word
);

	logic                          sticky;
	logic [4:0]                    sh;
	logic [f32d_pkg::ExpW-1:0]     sh_full;
	logic [f32d_pkg::QuoBits-1:0]  lost_mask;
	logic [f32d_pkg::QuoBits-1:0]  qs;
	logic                          sticky_sub;
	logic [23:0]                   m_norm;
	logic [23:0]                   m_sub;
	logic [31:0]                   res;
	logic [31:0]                   word_q;
	logic                          vld_q;

	always_comb begin
		sticky  = |cell_in.rem;
		sh_full = 10'sd1 - cell_in.expo;
		sh      = (sh_full > 10'd25) ? 5'd25 : sh_full[4:0];
		lost_mask  = ~({f32d_pkg::QuoBits{1'b1}} << sh);
		qs         = cell_in.quo >> sh;
		sticky_sub = sticky | (|(cell_in.quo & lost_mask));
		m_norm = cell_in.quo[24:1]
		       + {23'd0, cell_in.quo[0] & (sticky | cell_in.quo[1])};
		m_sub  = qs[24:1] + {23'd0, qs[0] & (sticky_sub | qs[1])};
		if (cell_in.expo > f32d_pkg::ExpMax) begin
			res = f32d_pkg::InfWord;
		end else if (cell_in.expo >= 10'sd1) begin
			res = {cell_in.expo[8:0], 23'd0} + {8'd0, m_norm - f32d_pkg::HiddenBit};
		end else begin
			res = {8'd0, m_sub};
		end
		res = res | {cell_in.sign, 31'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= cell_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= res;
		end
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;

endmodule

// ----- src/float32_divider.sv -----
`timescale 1ns / 1ps
// An accepted operand beat passes through one setup cell, 25 division cells and
// one rounding register before it leaves as the result beat.
// Throughput: one division per cycle while the output beat is not held; the row of 25 restoring cells sets this.
// The whole row stalls only when the output beat is held by a low ready.
// Reset clears the setup cell and the division cells; the output word is not reset.
// ----------------------------------------------------------------------------
// float32_divider
// Pipelined single-precision divider built as a chain of division cells.
// ----------------------------------------------------------------------------
module float32_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] numerator_word,
	input  logic [31:0] denominator_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] quotient_word
);

	localparam int unsigned N = f32d_pkg::QuoBits;

	f32d_pkg::f32d_cell_t chain [0:N];
	f32d_pkg::f32d_cell_t setup_q;
	logic                 advance;
	logic [23:0]          x;
	logic [23:0]          y;
	logic                 lt;
	logic signed [f32d_pkg::ExpW-1:0] e0;

	assign advance  = ~out_valid | out_ready;
	assign in_ready = advance;

	always_comb begin
		x  = {1'b1, numerator_word[22:0]};
		y  = {1'b1, denominator_word[22:0]};
		lt = x < y;
		e0 = $signed({2'b00, numerator_word[30:23]}) - $signed({2'b00, denominator_word[30:23]})
		   + f32d_pkg::ExpBias - (lt ? 10'sd1 : 10'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= '0;
		end else if (advance) begin
			setup_q.vld  <= in_valid;
			setup_q.sign <= numerator_word[31] ^ denominator_word[31];
			setup_q.expo <= e0;
			setup_q.dvs  <= y;
			setup_q.rem  <= lt ? {x, 1'b0} : {1'b0, x};
			setup_q.quo  <= '0;
		end
	end

	assign chain[0] = setup_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		f32d_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	f32d_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cell_in  (chain[N]),
		.out_vld  (out_valid),
		.out_word (quotient_word)
	);

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the pipelined single-precision divider against a bit-exact
// predictor, with directed and random operand pairs and random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

	localparam int IdleLimit = 5000;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
	} operand_pair_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] numerator_word;
	logic [31:0] denominator_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] quotient_word;

	operand_pair_t pending_pairs[$];
	logic [31:0]   expected_quotients[$];
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_off_cycles;
	int  idle_count;
	int  error_count;

	float32_divider dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.numerator_word(numerator_word), .denominator_word(denominator_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.quotient_word(quotient_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Rounds a 25-bit quotient (round bit in bit 0) to nearest even.
	function automatic logic [31:0] round_even(logic [31:0] q, logic sticky);
		logic rbit;
		logic odd;
		rbit = q[0];
		odd = q[1];
		return (q >> 1) + {31'd0, rbit & (sticky | odd)};
	endfunction

	function automatic logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] q;
		logic [31:0] res;
		logic [31:0] lost;
		logic        sticky;
		int          e;
		int          sh;
		e = int'(a[30:23]) - int'(b[30:23]) + 127;
		x = {8'd0, 1'b1, a[22:0]};
		y = {8'd0, 1'b1, b[22:0]};
		q = 0;
		if (x < y) begin
			x = x << 1;
			e = e - 1;
		end
		for (int k = 0; k < f32d_pkg::QuoBits; k++) begin
			q = q << 1;
			if (x >= y) begin
				x = x - y;
				q[0] = 1'b1;
			end
			x = x << 1;
		end
		sticky = (x != 0);
		if (e >= 1 && e <= 254) begin
			res = (32'(e) << 23) + (round_even(q, sticky) - 32'h0080_0000);
		end else if (e > 254) begin
			res = f32d_pkg::InfWord;
		end else begin
			sh = 1 - e;
			if (sh > f32d_pkg::QuoBits) sh = f32d_pkg::QuoBits;
			lost = q & ((32'd1 << sh) - 1);
			if (lost != 0) sticky = 1'b1;
			q = q >> sh;
			res = round_even(q, sticky);
		end
		return res | {a[31] ^ b[31], 31'd0};
	endfunction

	function automatic logic [31:0] make_word(logic s, logic [7:0] e, logic [22:0] f);
		return {s, e, f};
	endfunction

	task automatic queue_pair(logic [31:0] a, logic [31:0] b);
		operand_pair_t p;
		p.num = a;
		p.den = b;
		pending_pairs.push_back(p);
	endtask

	function automatic logic [31:0] random_word();
		int e;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) return $urandom();
		// Most exponents sit near the bias; some stray to the extremes.
		if (kind < 7) e = $urandom_range(100, 154);
		else e = $urandom_range(0, 255);
		return make_word(1'($urandom_range(0, 1)), 8'(e), 23'($urandom()));
	endfunction

	// Driver: holds a beat until accepted, otherwise pulls the next pair.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			numerator_word <= '0;
			denominator_word <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				operand_pair_t p;
				p = pending_pairs.pop_front();
				in_valid <= 1'b1;
				numerator_word <= p.num;
				denominator_word <= p.den;
				expected_quotients.push_back(predict_quotient(p.num, p.den));
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver ready, with an optional long hold-off counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_quotients.size() == 0) begin
					$error("quotient_word: unexpected beat, actual %h", quotient_word);
					error_count++;
				end else begin
					logic [31:0] want;
					want = expected_quotients.pop_front();
					if (want !== quotient_word) begin
						$error("quotient_word: expected %h, actual %h", want, quotient_word);
						error_count++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off_cycles > 0)
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= IdleLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic run_phase(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) queue_pair(random_word(), random_word());
		wait (pending_pairs.size() == 0);
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		idle_count = 0;
		error_count = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, exact quotients, ties, overflow and underflow.
		queue_pair(32'h3F80_0000, 32'h3F80_0000);
		queue_pair(32'h4040_0000, 32'h3F80_0000);
		queue_pair(32'h3F80_0000, 32'h4040_0000);
		queue_pair(32'hBF80_0000, 32'h4000_0000);
		queue_pair(32'h3F80_0000, 32'hBFFF_FFFF);
		queue_pair(32'h3FFF_FFFF, 32'h3F80_0000);
		queue_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);
		queue_pair(32'h7F7F_FFFF, 32'h3F00_0000);
		queue_pair(32'h7F7F_FFFF, 32'h3F80_0001);
		queue_pair(32'h7FFF_FFFF, 32'h0000_0000);
		queue_pair(32'hFFFF_FFFF, 32'h8000_0000);
		queue_pair(32'h0000_0000, 32'h7FFF_FFFF);
		queue_pair(32'h8000_0000, 32'hFF80_0000);
		queue_pair(32'h0080_0000, 32'h3F80_0001);
		queue_pair(32'h0080_0000, 32'h4000_0000);
		queue_pair(32'h00FF_FFFF, 32'h4000_0000);
		queue_pair(32'h0080_0000, 32'h4B00_0000);
		queue_pair(32'h0080_0000, 32'h4C00_0000);
		queue_pair(32'h0080_0000, 32'h4B40_0000);
		queue_pair(32'h0000_0001, 32'h7F00_0000);
		queue_pair(32'h3F80_0000, 32'h3F80_0001);
		queue_pair(32'h7F00_0000, 32'h0080_0000);
		queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
		queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
		wait (pending_pairs.size() == 0);

		run_phase(140, 0, 0);
		run_phase(130, 55, 0);
		run_phase(130, 0, 55);
		// Long hold-off while the sender keeps offering, to fill the row.
		hold_off_cycles = 200;
		run_phase(60, 0, 0);
		run_phase(90, 19, 19);

		wait (expected_quotients.size() == 0 && !in_valid);
		repeat (40) @(posedge clk);
		if (error_count == 0 && expected_quotients.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- float32_divider.f -----
src/f32d_pkg.sv
src/f32d_cell.sv
src/f32d_round.sv
src/float32_divider.sv
verif/tb.sv
